>>> design/qap_cost_and_swap_delta_macros.svh
// Assertion macros used by the QAP command sequencer
`ifndef QAP_COST_AND_SWAP_DELTA_MACROS_SVH
`define QAP_COST_AND_SWAP_DELTA_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising edge outside reset
`define QAP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qap assertion failed");
// next-cycle implication
`define QAP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qap assertion failed");
`else
`define QAP_ASSERT_IMP(lbl, ante, cons)
`define QAP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/qap_pkg.sv
// Shared types, widths and command codes of the QAP evaluation engine
package qap_pkg;

  localparam int DEF_MAX_N      = 128;
  localparam int DEF_ENTRY_BITS = 16;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 48;
  localparam int PSIZE_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_FLOW   = 3'd0,
    CMD_WR_DIST   = 3'd1,
    CMD_WR_ASSIGN = 3'd2,
    CMD_COST      = 3'd3,
    CMD_DELTA     = 3'd4,
    CMD_SWAP      = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic                       status;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // item accepted: latch operands, clear result
    logic rd_rs;  // read assignment at r and s
    logic cap_p;  // capture p[r], p[s]
    logic issue;  // issue one walk step into the MAC pipeline
    logic wr_r;   // write p[r] <= old p[s]
    logic wr_s;   // write p[s] <= old p[r]
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic imm_err;    // index error of the item at the input
    logic walk_last;  // current walk step is the last one
    logic pipe_busy;  // MAC pipeline holds steps
    logic n_zero;     // size in use is zero
  } dp_status_t;

endpackage

>>> design/qap_ctrl.sv
// Command sequencer of the QAP evaluation engine
`include "qap_cost_and_swap_delta_macros.svh"

module qap_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  logic [qap_pkg::CMD_W-1:0]   code,
  input  logic                        out_free,
  input  qap_pkg::dp_status_t         status,
  output logic                        cmd_stall,
  output logic                        emit,
  output qap_pkg::ctl_t               ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_D_RD,
    S_D_CAP,
    S_SW_RD,
    S_SW_CAP,
    S_SW_WR_R,
    S_SW_WR_S,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   open;
  logic   accept;

  // an item can enter when idle, or when the pending result leaves this cycle
  assign open      = (state == S_IDLE) || ((state == S_FINISH) && out_free);
  assign cmd_stall = !open;
  assign accept    = cmd_valid && open;
  assign emit      = (state == S_FINISH) && out_free;

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.load   = accept;
    case (state)
      S_WALK: begin
        ctl.issue = 1'b1;
        if (status.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_D_RD: begin
        ctl.rd_rs  = 1'b1;
        state_next = S_D_CAP;
      end
      S_D_CAP: begin
        ctl.cap_p  = 1'b1;
        state_next = S_WALK;
      end
      S_SW_RD: begin
        ctl.rd_rs  = 1'b1;
        state_next = S_SW_CAP;
      end
      S_SW_CAP: begin
        ctl.cap_p  = 1'b1;
        state_next = S_SW_WR_R;
      end
      S_SW_WR_R: begin
        ctl.wr_r   = 1'b1;
        state_next = S_SW_WR_S;
      end
      S_SW_WR_S: begin
        ctl.wr_s   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = state;
      end
    endcase

    // branch on the accepted command
    if (accept) begin
      case (code)
        qap_pkg::CMD_COST: begin
          state_next = status.n_zero ? S_FINISH : S_WALK;
        end
        qap_pkg::CMD_DELTA: begin
          state_next = status.imm_err ? S_FINISH : S_D_RD;
        end
        qap_pkg::CMD_SWAP: begin
          state_next = status.imm_err ? S_FINISH : S_SW_RD;
        end
        default: begin
          state_next = S_FINISH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `QAP_ASSERT_IMP(a_idle_pipe_empty, state == S_IDLE, !status.pipe_busy)
  `QAP_ASSERT_IMP(a_emit_drained, emit, !status.pipe_busy)
  `QAP_ASSERT_NXT(a_swap_write_pair, ctl.wr_r, ctl.wr_s)
  `QAP_ASSERT_NXT(a_issue_fills_pipe, ctl.issue, status.pipe_busy)

endmodule

>>> design/qap_dp.sv
// Datapath: matrix and assignment memories, walk counters, MAC pipeline
module qap_dp #(
  parameter int MAX_N      = qap_pkg::DEF_MAX_N,
  parameter int ENTRY_BITS = qap_pkg::DEF_ENTRY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qap_pkg::in_item_t             item,
  input  logic [qap_pkg::PSIZE_W-1:0]   problem_size,
  input  qap_pkg::ctl_t                 ctl,
  output qap_pkg::dp_status_t           status,
  output qap_pkg::out_item_t            res
);

  localparam int AW  = $clog2(MAX_N);
  localparam int NW  = $clog2(MAX_N + 1);
  localparam int CW  = (NW > qap_pkg::VALUE_W) ? NW : qap_pkg::VALUE_W;
  localparam int SW  = (NW > qap_pkg::PSIZE_W) ? NW : qap_pkg::PSIZE_W;
  localparam int MD  = 1 << (2 * AW);
  localparam int EB  = ENTRY_BITS;
  localparam int PW  = 2 * EB + 2;
  localparam int RW  = qap_pkg::RESULT_W;

  // size in use, saturated to MAX_N
  logic [NW-1:0] n;
  logic [AW-1:0] nl;
  logic          row_bad;
  logic          col_bad;
  logic          val_bad;
  logic          imm_err;

  assign n  = (SW'(problem_size) > SW'(MAX_N)) ? NW'(MAX_N) : NW'(problem_size);
  assign nl = AW'(n - NW'(1));

  assign row_bad = CW'(item.row) >= CW'(n);
  assign col_bad = CW'(item.col) >= CW'(n);
  assign val_bad = CW'(item.value) >= CW'(n);

  // index checks of the item at the input
  always_comb begin
    case (item.cmd)
      qap_pkg::CMD_WR_FLOW,
      qap_pkg::CMD_WR_DIST,
      qap_pkg::CMD_DELTA,
      qap_pkg::CMD_SWAP:      imm_err = row_bad || col_bad;
      qap_pkg::CMD_WR_ASSIGN: imm_err = row_bad || val_bad;
      qap_pkg::CMD_COST:      imm_err = 1'b0;
      default:                imm_err = 1'b1;
    endcase
  end

  // operands latched at accept
  logic [AW-1:0] r_q;
  logic [AW-1:0] s_q;
  logic          mode_cost;
  logic [AW-1:0] pr;
  logic [AW-1:0] ps;

  // walk counters: cost walks (ci, cj), delta walks (ci = k, ch = half)
  logic [AW-1:0] ci;
  logic [AW-1:0] cj;
  logic          ch;
  logic          walk_last;

  assign walk_last = mode_cost ? ((ci == nl) && (cj == nl)) : ((ci == nl) && ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
      ch <= 1'b0;
    end else if (ctl.load) begin
      ci <= '0;
      cj <= '0;
      ch <= 1'b0;
    end else if (ctl.issue) begin
      if (mode_cost) begin
        if (cj == nl) begin
          cj <= '0;
          ci <= ci + AW'(1);
        end else begin
          cj <= cj + AW'(1);
        end
      end else begin
        ch <= !ch;
        if (ch) begin
          ci <= ci + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_q       <= AW'(item.row);
      s_q       <= AW'(item.col);
      mode_cost <= (item.cmd == qap_pkg::CMD_COST);
    end
  end

  // assignment memory: one write port, two registered read ports
  logic [AW-1:0] asg_mem [MAX_N];
  logic [AW-1:0] asg_ra;
  logic [AW-1:0] asg_rb;
  logic [AW-1:0] pa;
  logic [AW-1:0] pb;
  logic          asg_we;
  logic [AW-1:0] asg_wa;
  logic [AW-1:0] asg_wd;

  assign asg_ra = ctl.rd_rs ? r_q : ci;
  assign asg_rb = ctl.rd_rs ? s_q : cj;

  always_comb begin
    asg_we = 1'b0;
    asg_wa = AW'(item.row);
    asg_wd = AW'(item.value);
    if (ctl.load && (item.cmd == qap_pkg::CMD_WR_ASSIGN) && !imm_err) begin
      asg_we = 1'b1;
    end else if (ctl.wr_r) begin
      asg_we = 1'b1;
      asg_wa = r_q;
      asg_wd = ps;
    end else if (ctl.wr_s) begin
      asg_we = 1'b1;
      asg_wa = s_q;
      asg_wd = pr;
    end
  end

  always_ff @(posedge clk) begin
    if (asg_we) begin
      asg_mem[asg_wa] <= asg_wd;
    end
    pa <= asg_mem[asg_ra];
    pb <= asg_mem[asg_rb];
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_p) begin
      pr <= pa;
      ps <= pb;
    end
  end

  // stage 1: step control alongside the assignment read
  logic          v1;
  logic          h1;
  logic          skip1;
  logic [AW-1:0] i1;
  logic [AW-1:0] j1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
    end
    h1    <= ch;
    i1    <= ci;
    j1    <= cj;
    skip1 <= !mode_cost && ((ci == r_q) || (ci == s_q));
  end

  // matrix addresses from the step and the assignment read
  logic [2*AW-1:0] fa_addr;
  logic [2*AW-1:0] fb_addr;
  logic [2*AW-1:0] da_addr;
  logic [2*AW-1:0] db_addr;
  logic [2*AW-1:0] wr_addr;
  logic            stale1;

  assign stale1  = (NW'(pa) >= n) || (mode_cost && (NW'(pb) >= n));
  assign wr_addr = {AW'(item.row), AW'(item.col)};

  always_comb begin
    if (mode_cost) begin
      fa_addr = {i1, j1};
      fb_addr = {i1, j1};
      da_addr = {pa, pb};
      db_addr = {pa, pb};
    end else if (!h1) begin
      fa_addr = {r_q, i1};
      fb_addr = {s_q, i1};
      da_addr = {ps, pa};
      db_addr = {pr, pa};
    end else begin
      fa_addr = {i1, r_q};
      fb_addr = {i1, s_q};
      da_addr = {pa, ps};
      db_addr = {pa, pr};
    end
  end

  // flow and distance memories, registered reads on two ports each
  logic [EB-1:0] flow_mem [MD];
  logic [EB-1:0] dist_mem [MD];
  logic [EB-1:0] fa;
  logic [EB-1:0] fb;
  logic [EB-1:0] da;
  logic [EB-1:0] db;

  always_ff @(posedge clk) begin
    if (ctl.load && (item.cmd == qap_pkg::CMD_WR_FLOW) && !imm_err) begin
      flow_mem[wr_addr] <= EB'(item.value);
    end
    fa <= flow_mem[fa_addr];
    fb <= flow_mem[fb_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load && (item.cmd == qap_pkg::CMD_WR_DIST) && !imm_err) begin
      dist_mem[wr_addr] <= EB'(item.value);
    end
    da <= dist_mem[da_addr];
    db <= dist_mem[db_addr];
  end

  // stage 2 control
  logic v2;
  logic skip2;
  logic stale2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    skip2  <= skip1;
    stale2 <= stale1;
  end

  // stage 3: flow and distance differences (cost uses the A ports only)
  logic               v3;
  logic               skip3;
  logic               stale3;
  logic signed [EB:0] sa;
  logic signed [EB:0] sb;
  logic [EB-1:0]      fbz;
  logic [EB-1:0]      dbz;

  assign fbz = mode_cost ? '0 : fb;
  assign dbz = mode_cost ? '0 : db;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    skip3  <= skip2;
    stale3 <= stale2;
    sa     <= $signed({1'b0, fa}) - $signed({1'b0, fbz});
    sb     <= $signed({1'b0, da}) - $signed({1'b0, dbz});
  end

  // stage 4: product
  logic                 v4;
  logic                 skip4;
  logic                 stale4;
  logic signed [PW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    skip4  <= skip3;
    stale4 <= stale3;
    prod   <= sa * sb;
  end

  // accumulator and error flag, wrapping modulo 2^48
  logic [RW-1:0] acc;
  logic          err;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= '0;
      err <= imm_err;
    end else if (v4) begin
      if (!skip4) begin
        acc <= acc + RW'(prod);
      end
      if (stale4) begin
        err <= 1'b1;
      end
    end
  end

  assign res.result = err ? '0 : $signed(acc);
  assign res.status = err;

  assign status.imm_err   = imm_err;
  assign status.walk_last = walk_last;
  assign status.pipe_busy = v1 || v2 || v3 || v4;
  assign status.n_zero    = (n == '0);

endmodule

>>> design/qap_cost_and_swap_delta.sv
// Each item yields one result item on res_valid, held back while res_stall holds.
// The matrix walk issues one product a cycle through a shared multiply-accumulate
// pipe fed by two-port flow and distance memories; writes sustain one item a cycle
// while res_stall is low.
// Synchronous reset clears control and sets problem_size to 2; the memories keep
// their contents and read as unknown until written.
module qap_cost_and_swap_delta #(
  parameter int MAX_N      = qap_pkg::DEF_MAX_N,
  parameter int ENTRY_BITS = qap_pkg::DEF_ENTRY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  qap_pkg::in_item_t   cmd_item,
  // result items
  output logic                res_valid,
  input  logic                res_stall,
  output qap_pkg::out_item_t  res_item,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic REG_PROBLEM_SIZE = 1'b0;
  localparam logic [qap_pkg::PSIZE_W-1:0] PSIZE_RESET = 8'd2;

  logic [qap_pkg::PSIZE_W-1:0] problem_size;
  logic                        out_free;
  logic                        emit;
  qap_pkg::ctl_t               ctl;
  qap_pkg::dp_status_t         status;
  qap_pkg::out_item_t          dp_res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PROBLEM_SIZE) ? 32'(problem_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      problem_size <= PSIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PROBLEM_SIZE)) begin
      problem_size <= pwdata[qap_pkg::PSIZE_W-1:0];
    end
  end

  // output register
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_item <= dp_res;
    end
  end

  qap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .code      (cmd_item.cmd),
    .out_free  (out_free),
    .status    (status),
    .cmd_stall (cmd_stall),
    .emit      (emit),
    .ctl       (ctl)
  );

  qap_dp #(
    .MAX_N      (MAX_N),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (cmd_item),
    .problem_size (problem_size),
    .ctl          (ctl),
    .status       (status),
    .res          (dp_res)
  );

endmodule
